// ----- design/nmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest-mean classifier package
// Shared constants, codes and payload types of the classifier core.
// ----------------------------------------------------------------------------
package nmc_pkg;

	localparam int NUM_CLASSES = 16;
	localparam int NUM_BANDS   = 8;
	localparam int BIDX_W      = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

	localparam logic [23:0] INV_ONE = 24'd65536;

	localparam logic [2:0] CFG_MODE     = 3'd0;
	localparam logic [2:0] CFG_MAX_DIST = 3'd1;
	localparam logic [2:0] CFG_ND_EN    = 3'd2;
	localparam logic [2:0] CFG_ND_VAL   = 3'd3;
	localparam logic [2:0] CFG_COUNT    = 3'd4;

	localparam logic [1:0] REQ_SIG    = 2'd0;
	localparam logic [1:0] REQ_LABEL  = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	localparam logic [1:0] OUT_CLASSIFIED = 2'd0;
	localparam logic [1:0] OUT_NODATA     = 2'd1;
	localparam logic [1:0] OUT_REJECTED   = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  class_index;
		logic [2:0]  band_index;
		logic [15:0] mean_value;
		logic [23:0] inv_stddev;
		logic [15:0] label_value;
		logic [15:0] sample;
		logic        last_band;
	} pix_item_t;

	typedef struct packed {
		logic [15:0] class_label;
		logic [1:0]  outcome;
	} res_item_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  band;
		logic [15:0] sample;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		logic        have;
		logic [63:0] sum;
		logic [15:0] label;
	} best_t;

	typedef struct packed {
		logic        sig_we;
		logic        lab_we;
		logic [2:0]  band;
		logic [15:0] mean;
		logic [23:0] inv;
		logic [15:0] label;
	} load_t;

endpackage

// ----- design/nmc_cell.sv -----
// ----------------------------------------------------------------------------
// Nearest-mean classifier cell
// Holds one class signature and its distance sum, and passes the sample and
// the running best class to its neighbour.
// ----------------------------------------------------------------------------
module nmc_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mode,
	input  logic          active,
	input  nmc_pkg::load_t ld,
	input  nmc_pkg::tok_t  tok_in,
	output nmc_pkg::tok_t  tok_out,
	input  nmc_pkg::best_t best_in,
	output nmc_pkg::best_t best_out
);
	import nmc_pkg::*;

	logic [15:0] mean_q [NUM_BANDS];
	logic [23:0] inv_q  [NUM_BANDS];
	logic [15:0] label_q;
	logic [63:0] sum_q;

	logic [BIDX_W-1:0] bi;
	logic              rng;
	logic [15:0]       m;
	logic [15:0]       ad;
	logic [39:0]       p_std;
	logic [31:0]       p_euc;

	logic        v_s1, last_s1, zero_s1;
	logic [2:0]  band_s1;
	logic [15:0] samp_s1;
	logic [39:0] prod_s1;
	logic        v_s2, last_s2, zero_s2;
	logic [31:0] euc_s2;
	logic [39:0] hh_s2, hl_s2, ll_s2;
	logic        v_s3, last_s3;
	logic [63:0] term_s3;
	logic [65:0] tsum;
	logic [63:0] term;
	logic [64:0] nsum;
	logic [63:0] ns;
	logic        take;
	logic        best_valid_q;
	logic        best_last_q;
	logic        best_have_q;
	logic [63:0] best_sum_q;
	logic [15:0] best_label_q;

	assign bi    = tok_in.band[BIDX_W-1:0];
	assign rng   = 32'(tok_in.band) < NUM_BANDS;
	assign m     = mean_q[bi];
	assign ad    = (tok_in.sample >= m) ? tok_in.sample - m : m - tok_in.sample;
	assign p_std = ad * inv_q[bi];
	assign p_euc = ad * ad;

	always_ff @(posedge clk) begin
		if (ld.sig_we) begin
			mean_q[ld.band[BIDX_W-1:0]] <= ld.mean;
		end
		if (ld.lab_we) begin
			label_q <= ld.label;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANDS; b++) begin
				inv_q[b] <= INV_ONE;
			end
		end else if (ld.sig_we) begin
			inv_q[ld.band[BIDX_W-1:0]] <= ld.inv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			best_valid_q <= 1'b0;
			sum_q <= '0;
		end else begin
			v_s1 <= tok_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			best_valid_q <= v_s3;
			if (v_s3) begin
				sum_q <= last_s3 ? 64'd0 : ns;
			end
		end
	end

	always_ff @(posedge clk) begin
		band_s1 <= tok_in.band;
		samp_s1 <= tok_in.sample;
		last_s1 <= tok_in.last;
		zero_s1 <= !rng;
		prod_s1 <= mode ? p_std : {8'd0, p_euc};
		last_s2 <= last_s1;
		zero_s2 <= zero_s1;
		euc_s2  <= prod_s1[31:0];
		hh_s2   <= prod_s1[39:20] * prod_s1[39:20];
		hl_s2   <= prod_s1[39:20] * prod_s1[19:0];
		ll_s2   <= prod_s1[19:0] * prod_s1[19:0];
		last_s3 <= last_s2;
		term_s3 <= term;
		best_last_q <= last_s3;
		if (take) begin
			best_have_q  <= 1'b1;
			best_sum_q   <= ns;
			best_label_q <= label_q;
		end else begin
			best_have_q  <= best_in.have;
			best_sum_q   <= best_in.sum;
			best_label_q <= best_in.label;
		end
	end

	always_comb begin
		tsum = {2'b0, hh_s2, 24'd0} + {21'd0, hl_s2, 5'd0} + {42'd0, ll_s2[39:16]};
		if (zero_s2) begin
			term = '0;
		end else if (mode) begin
			term = (tsum[65:64] != 2'b0) ? '1 : tsum[63:0];
		end else begin
			term = {16'd0, euc_s2, 16'd0};
		end
	end

	assign nsum = {1'b0, sum_q} + {1'b0, term_s3};
	assign ns   = nsum[64] ? '1 : nsum[63:0];
	assign take = active && (!best_in.have || (ns < best_in.sum));

	assign tok_out  = '{valid: v_s1, band: band_s1, sample: samp_s1, last: last_s1};
	assign best_out = '{valid: best_valid_q, last: best_last_q, have: best_have_q,
		sum: best_sum_q, label: best_label_q};

endmodule

// ----- design/nearest_mean_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Nearest-mean classifier core
// Minimum distance to class means over a row of class cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake        Payload
//  pix      in         valid / stall    pix_item_t
//  res      out        valid / stall    res_item_t
//  cfg      in         valid / ready    register index and data
//
// A load item writes its cell as it is taken. A sample item runs through the
// cell row: the sample moves one cell a cycle and each cell has a four-stage
// distance pipeline; no new item is taken until it leaves the row. Reset
// clears all sums and sets every reciprocal deviation to one at once. A stalled
// result waits in the output register, with one further slot behind it.
// ----------------------------------------------------------------------------
module nearest_mean_classifier_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  nmc_pkg::pix_item_t pix_data,
	output logic               res_valid,
	input  logic               res_stall,
	output nmc_pkg::res_item_t res_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [62:0]        cfg_data
);
	import nmc_pkg::*;

	logic        mode_q, nd_en_q;
	logic [62:0] thr_q;
	logic [15:0] nd_val_q;
	logic [4:0]  cc_q;
	logic        busy_q, nodata_q;
	logic        res_valid_q, pend_v_q;
	res_item_t   res_q, pend_q, new_res;
	logic        accept, take, fin, fin_last;

	tok_t  tok_w  [NUM_CLASSES+1];
	best_t best_w [NUM_CLASSES+1];

	assign cfg_ready = 1'b1;
	assign pix_stall = busy_q || pend_v_q;
	assign accept    = pix_valid && !pix_stall;
	assign take      = res_valid_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			thr_q    <= '0;
			nd_en_q  <= 1'b0;
			nd_val_q <= '0;
			cc_q     <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:     mode_q   <= cfg_data[0];
				CFG_MAX_DIST: thr_q    <= cfg_data;
				CFG_ND_EN:    nd_en_q  <= cfg_data[0];
				CFG_ND_VAL:   nd_val_q <= cfg_data[15:0];
				CFG_COUNT:    cc_q     <= cfg_data[4:0];
				default:      ;
			endcase
		end
	end

	assign tok_w[0]  = '{valid: accept && (pix_data.req_type == REQ_SAMPLE),
		band: pix_data.band_index, sample: pix_data.sample, last: pix_data.last_band};
	assign best_w[0] = '0;

	for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_cell
		load_t ld;
		logic  sel;
		assign sel = accept && (32'(pix_data.class_index) == i);
		assign ld  = '{sig_we: sel && (pix_data.req_type == REQ_SIG)
				&& (32'(pix_data.band_index) < NUM_BANDS),
			lab_we: sel && (pix_data.req_type == REQ_LABEL),
			band: pix_data.band_index, mean: pix_data.mean_value,
			inv: pix_data.inv_stddev, label: pix_data.label_value};
		nmc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.mode     (mode_q),
			.active   ((i == 0) || (32'(cc_q) > i)),
			.ld       (ld),
			.tok_in   (tok_w[i]),
			.tok_out  (tok_w[i+1]),
			.best_in  (best_w[i]),
			.best_out (best_w[i+1])
		);
	end

	assign fin      = best_w[NUM_CLASSES].valid;
	assign fin_last = fin && best_w[NUM_CLASSES].last;

	always_comb begin
		if (nodata_q) begin
			new_res = '{class_label: 16'd0, outcome: OUT_NODATA};
		end else if ((thr_q != '0) && (best_w[NUM_CLASSES].sum > {1'b0, thr_q})) begin
			new_res = '{class_label: 16'd0, outcome: OUT_REJECTED};
		end else begin
			new_res = '{class_label: best_w[NUM_CLASSES].label, outcome: OUT_CLASSIFIED};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			nodata_q    <= 1'b0;
			res_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
		end else begin
			if (tok_w[0].valid) begin
				busy_q <= 1'b1;
				if ((pix_data.band_index == 3'd0) && nd_en_q
						&& (pix_data.sample == nd_val_q)) begin
					nodata_q <= 1'b1;
				end
			end else if (fin) begin
				busy_q <= 1'b0;
				if (fin_last) begin
					nodata_q <= 1'b0;
				end
			end
			if (pend_v_q && (!res_valid_q || take)) begin
				res_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
			end else if (fin_last) begin
				if (!res_valid_q || take) begin
					res_valid_q <= 1'b1;
				end else begin
					pend_v_q <= 1'b1;
				end
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_q && (!res_valid_q || take)) begin
			res_q <= pend_q;
		end else if (fin_last) begin
			if (!res_valid_q || take) begin
				res_q <= new_res;
			end else begin
				pend_q <= new_res;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_pend_behind: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> res_valid_q) else $error("spare slot full with output empty");
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> busy_q) else $error("cell row finished with no item in flight");
	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		fin_last |-> !pend_v_q) else $error("result arrived with no room");
	a_zero_label: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.outcome != OUT_CLASSIFIED)) |-> (res_q.class_label == 16'd0))
		else $error("unclassified result carries a label");

endmodule
